@@ hdl/hbw_pkg.sv @@
// ----------------------------------------------------------------------------
// hbw_pkg
// Shared types, codes and constants of the histogram and bias-weight engine.
// ----------------------------------------------------------------------------
package hbw_pkg;

	// defaults for the top level parameters
	localparam int MAX_BINS_DEF  = 256;
	localparam int FRAC_BITS_DEF = 48;

	// operation codes
	localparam logic [2:0] FN_SAMPLE   = 3'd0;
	localparam logic [2:0] FN_RESET    = 3'd1;
	localparam logic [2:0] FN_SHIFT    = 3'd2;
	localparam logic [2:0] FN_READ     = 3'd3;
	localparam logic [2:0] FN_WRITE    = 3'd4;
	localparam logic [2:0] FN_SET_ITER = 3'd5;

	// configuration register indexes
	localparam logic [2:0] CFG_RANGE_MIN = 3'd0;
	localparam logic [2:0] CFG_RANGE_MAX = 3'd1;
	localparam logic [2:0] CFG_BIN_WIDTH = 3'd2;
	localparam logic [2:0] CFG_NUM_BINS  = 3'd3;
	localparam logic [2:0] CFG_ITER_TOL  = 3'd4;

	// configuration reset values
	localparam logic [31:0] RST_RANGE_MIN = 32'd0;
	localparam logic [31:0] RST_RANGE_MAX = 32'd256;
	localparam logic [30:0] RST_BIN_WIDTH = 31'd1;
	localparam logic [8:0]  RST_NUM_BINS  = 9'd256;
	localparam logic [5:0]  RST_ITER_TOL  = 6'd25;

	// iteration limits
	localparam logic [5:0] ITER_MIN = 6'd1;
	localparam logic [5:0] ITER_MAX = 6'd63;

	// bin index division, one quotient bit per cycle
	localparam int DIV_STEPS = 32;
	localparam int DIV_CW    = $clog2(DIV_STEPS);

	// saturation bounds
	localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;
	localparam logic [63:0] W_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] W_MIN   = 64'h8000_0000_0000_0000;

	// commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic fail;
		logic div_start;
		logic div_step;
		logic clamp;
		logic sel_idx;
		logic rd_ctr;
		logic upd;
		logic neg;
		logic clr_all;
		logic clr_cnt;
		logic max_cmp;
		logic sub_wr;
		logic wr_weight;
		logic iter_inc;
		logic set_iter;
		logic ctr_clr;
		logic ctr_inc;
		logic out_load;
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic [2:0] func;
		logic       in_range;
		logic       sel_ok;
		logic       div_last;
		logic       ctr_last_all;
		logic       ctr_last_nb;
		logic       out_free;
	} stat_t;

endpackage

@@ hdl/hbw_ram.sv @@
// ----------------------------------------------------------------------------
// hbw_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module hbw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/hbw_ctrl.sv @@
// ----------------------------------------------------------------------------
// hbw_ctrl
// Sequencer of the engine: clearing pass, operation dispatch, division,
// read-modify-write, bin sweeps and result hand-off.
// ----------------------------------------------------------------------------
module hbw_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  hbw_pkg::stat_t stat,
	output hbw_pkg::cmd_t  cmd
);

	import hbw_pkg::*;

	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_DISP   = 4'd2;
	localparam logic [3:0] ST_DIV    = 4'd3;
	localparam logic [3:0] ST_CLAMP  = 4'd4;
	localparam logic [3:0] ST_RD     = 4'd5;
	localparam logic [3:0] ST_UPD    = 4'd6;
	localparam logic [3:0] ST_NEG    = 4'd7;
	localparam logic [3:0] ST_CLRC   = 4'd8;
	localparam logic [3:0] ST_MAXRD  = 4'd9;
	localparam logic [3:0] ST_MAXCMP = 4'd10;
	localparam logic [3:0] ST_SUBRD  = 4'd11;
	localparam logic [3:0] ST_SUBWR  = 4'd12;
	localparam logic [3:0] ST_WRW    = 4'd13;
	localparam logic [3:0] ST_DONE   = 4'd14;

	logic [3:0] state_q;
	logic [3:0] state_d;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_all = 1'b1;
				cmd.ctr_inc = 1'b1;
				if (stat.ctr_last_all) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DISP;
				end
			end
			ST_DISP: begin
				case (stat.func)
					FN_SAMPLE: begin
						if (stat.in_range) begin
							cmd.div_start = 1'b1;
							state_d       = ST_DIV;
						end else begin
							cmd.fail = 1'b1;
							state_d  = ST_DONE;
						end
					end
					FN_RESET: begin
						cmd.iter_inc = 1'b1;
						cmd.ctr_clr  = 1'b1;
						state_d      = ST_CLRC;
					end
					FN_SHIFT: begin
						cmd.ctr_clr = 1'b1;
						state_d     = ST_MAXRD;
					end
					FN_READ: begin
						cmd.sel_idx = 1'b1;
						state_d     = stat.sel_ok ? ST_RD : ST_DONE;
					end
					FN_WRITE: begin
						cmd.sel_idx = 1'b1;
						state_d     = stat.sel_ok ? ST_WRW : ST_DONE;
					end
					FN_SET_ITER: begin
						cmd.set_iter = 1'b1;
						state_d      = ST_DONE;
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) state_d = ST_CLAMP;
			end
			ST_CLAMP: begin
				cmd.clamp = 1'b1;
				state_d   = ST_RD;
			end
			ST_RD: begin
				state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = ST_NEG;
			end
			ST_NEG: begin
				cmd.neg = 1'b1;
				state_d = ST_DONE;
			end
			ST_CLRC: begin
				cmd.clr_cnt = 1'b1;
				cmd.ctr_inc = 1'b1;
				if (stat.ctr_last_all) state_d = ST_DONE;
			end
			ST_MAXRD: begin
				cmd.rd_ctr = 1'b1;
				state_d    = ST_MAXCMP;
			end
			ST_MAXCMP: begin
				cmd.max_cmp = 1'b1;
				if (stat.ctr_last_nb) begin
					cmd.ctr_clr = 1'b1;
					state_d     = ST_SUBRD;
				end else begin
					cmd.ctr_inc = 1'b1;
					state_d     = ST_MAXRD;
				end
			end
			ST_SUBRD: begin
				cmd.rd_ctr = 1'b1;
				state_d    = ST_SUBWR;
			end
			ST_SUBWR: begin
				cmd.sub_wr = 1'b1;
				if (stat.ctr_last_nb) begin
					state_d = ST_DONE;
				end else begin
					cmd.ctr_inc = 1'b1;
					state_d     = ST_SUBRD;
				end
			end
			ST_WRW: begin
				cmd.wr_weight = 1'b1;
				state_d       = ST_DONE;
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ hdl/hbw_dp.sv @@
// ----------------------------------------------------------------------------
// hbw_dp
// Datapath: configuration registers, bin index divider, count and weight
// memories, saturating arithmetic, sweep counter and result register.
// ----------------------------------------------------------------------------
module hbw_dp #(
	parameter int MAX_BINS  = hbw_pkg::MAX_BINS_DEF,
	parameter int FRAC_BITS = hbw_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hbw_pkg::cmd_t       cmd,
	output hbw_pkg::stat_t      stat,
	// configuration
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	// input item
	input  logic [2:0]          func,
	input  logic signed [31:0]  value,
	input  logic                in_interval,
	input  logic [7:0]          bin_sel,
	input  logic signed [63:0]  weight_in,
	input  logic [5:0]          iteration_in,
	// result item
	output logic                out_valid,
	input  logic                out_ready,
	output logic                status,
	output logic [7:0]          bin_out,
	output logic [31:0]         count_out,
	output logic signed [63:0]  weight_out,
	output logic [5:0]          iteration_out,
	output logic                tol_exceeded,
	output logic [31:0]         total_samples
);

	import hbw_pkg::*;

	localparam int AW  = $clog2(MAX_BINS);
	localparam int NBW = $clog2(MAX_BINS + 1);

	// saturating 64 bit helpers
	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) return s[64] ? W_MIN : W_MAX;
		return s[63:0];
	endfunction

	function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63]) return s[64] ? W_MIN : W_MAX;
		return s[63:0];
	endfunction

	function automatic logic [63:0] sat_neg(input logic [63:0] a);
		if (a == W_MIN) return W_MAX;
		return 64'd0 - a;
	endfunction

	// configuration registers
	logic [31:0] rmin_q;
	logic [31:0] rmax_q;
	logic [30:0] bwidth_q;
	logic [8:0]  nbins_q;
	logic [5:0]  tol_q;

	// captured item
	logic [2:0]  func_q;
	logic [31:0] value_q;
	logic        inint_q;
	logic [7:0]  sel_q;
	logic [63:0] win_q;
	logic [5:0]  itin_q;

	// engine state
	logic [5:0]  iter_q;
	logic [31:0] total_q;
	logic [63:0] step_q;

	// work registers
	logic [30:0]       rem_q;
	logic [31:0]       quo_q;
	logic [DIV_CW-1:0] dcnt_q;
	logic [AW-1:0]     idx_q;
	logic [AW-1:0]     ctr_q;
	logic [31:0]       cnt_q;
	logic [63:0]       w_q;
	logic [63:0]       mx_q;

	// prepared result
	logic        res_status_q;
	logic [7:0]  res_bin_q;
	logic [31:0] res_cnt_q;
	logic [63:0] res_w_q;
	logic        res_tol_q;

	// output register
	logic        out_valid_q;
	logic        o_status_q;
	logic [7:0]  o_bin_q;
	logic [31:0] o_cnt_q;
	logic [63:0] o_w_q;
	logic [5:0]  o_iter_q;
	logic        o_tol_q;
	logic [31:0] o_total_q;

	// combinational
	logic [NBW-1:0] nb;
	logic [NBW-1:0] nb_m1;
	logic [30:0]    dv;
	logic [32:0]    diff;
	logic [31:0]    r_sh;
	logic           r_ge;
	logic [AW-1:0]  idx_next;
	logic [5:0]     h;
	logic [63:0]    step_d;
	logic [5:0]     iter_next;
	logic           sample_upd;
	logic [31:0]    cnt_new;
	logic [63:0]    w_new;
	logic [31:0]    rd_cnt;
	logic [63:0]    rd_w;
	logic           cnt_we;
	logic [31:0]    cnt_wdata;
	logic           wgt_we;
	logic [63:0]    wgt_wdata;
	logic [AW-1:0]  waddr;
	logic [AW-1:0]  raddr;

	// active bin count, clamped to 1..MAX_BINS
	always_comb begin
		if (nbins_q == 9'd0) begin
			nb = NBW'(1);
		end else if (32'(nbins_q) > 32'(MAX_BINS)) begin
			nb = NBW'(MAX_BINS);
		end else begin
			nb = NBW'(nbins_q);
		end
	end
	assign nb_m1 = nb - NBW'(1);

	// zero width acts as one
	assign dv = (bwidth_q == 31'd0) ? 31'd1 : bwidth_q;

	// offset from the lower bound, positive whenever the value is in range
	assign diff = {value_q[31], value_q} - {rmin_q[31], rmin_q};

	// one restoring division step
	assign r_sh = {rem_q, quo_q[31]};
	assign r_ge = r_sh >= {1'b0, dv};

	// clamp quotient to the last active bin
	always_comb begin
		if (quo_q >= 32'(nb)) begin
			idx_next = AW'(nb_m1);
		end else begin
			idx_next = AW'(quo_q);
		end
	end

	// step 2^-(iteration-1) in weight lsbs
	assign h = iter_q - 6'd1;
	always_comb begin
		if (int'(h) <= FRAC_BITS) begin
			step_d = 64'd1 << 6'(FRAC_BITS - int'(h));
		end else begin
			step_d = 64'd0;
		end
	end

	assign iter_next = (iter_q == ITER_MAX) ? ITER_MAX : iter_q + 6'd1;

	// read-modify-write of a sampled bin
	assign sample_upd = cmd.upd && (func_q == FN_SAMPLE);
	assign cnt_new    = (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + 32'd1;
	assign w_new      = inint_q ? sat_add(rd_w, step_q) : rd_w;

	// memory port selection
	assign raddr  = cmd.rd_ctr ? ctr_q : idx_q;
	assign waddr  = (sample_upd || cmd.wr_weight) ? idx_q : ctr_q;
	assign cnt_we = cmd.clr_all || cmd.clr_cnt || sample_upd;
	assign cnt_wdata = sample_upd ? cnt_new : 32'd0;
	assign wgt_we = cmd.clr_all || sample_upd || cmd.sub_wr || cmd.wr_weight;
	always_comb begin
		if (sample_upd) begin
			wgt_wdata = w_new;
		end else if (cmd.sub_wr) begin
			wgt_wdata = sat_sub(rd_w, mx_q);
		end else if (cmd.wr_weight) begin
			wgt_wdata = sat_neg(win_q);
		end else begin
			wgt_wdata = 64'd0;
		end
	end

	hbw_ram #(
		.WIDTH(32),
		.DEPTH(MAX_BINS)
	) u_counts (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(waddr),
		.wdata(cnt_wdata),
		.raddr(raddr),
		.rdata(rd_cnt)
	);

	hbw_ram #(
		.WIDTH(64),
		.DEPTH(MAX_BINS)
	) u_weights (
		.clk  (clk),
		.we   (wgt_we),
		.waddr(waddr),
		.wdata(wgt_wdata),
		.raddr(raddr),
		.rdata(rd_w)
	);

	// configuration port, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rmin_q   <= RST_RANGE_MIN;
			rmax_q   <= RST_RANGE_MAX;
			bwidth_q <= RST_BIN_WIDTH;
			nbins_q  <= RST_NUM_BINS;
			tol_q    <= RST_ITER_TOL;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_RANGE_MIN: rmin_q   <= cfg_data;
				CFG_RANGE_MAX: rmax_q   <= cfg_data;
				CFG_BIN_WIDTH: bwidth_q <= cfg_data[30:0];
				CFG_NUM_BINS:  nbins_q  <= cfg_data[8:0];
				CFG_ITER_TOL:  tol_q    <= cfg_data[5:0];
				default: begin
				end
			endcase
		end
	end

	// iteration and sample total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q  <= ITER_MIN;
			total_q <= 32'd0;
		end else begin
			if (cmd.iter_inc) begin
				iter_q  <= iter_next;
				total_q <= 32'd0;
			end else if (cmd.set_iter) begin
				iter_q <= (itin_q == 6'd0) ? ITER_MIN : itin_q;
			end else if (sample_upd && total_q != CNT_MAX) begin
				total_q <= total_q + 32'd1;
			end
		end
	end

	// sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= '0;
		end else if (cmd.ctr_clr) begin
			ctr_q <= '0;
		end else if (cmd.ctr_inc) begin
			ctr_q <= ctr_q + AW'(1);
		end
	end

	// item capture and working registers
	always_ff @(posedge clk) begin
		step_q <= step_d;
		if (cmd.capture) begin
			func_q  <= func;
			value_q <= value;
			inint_q <= in_interval;
			sel_q   <= bin_sel;
			win_q   <= weight_in;
			itin_q  <= iteration_in;
		end
		if (cmd.div_start) begin
			rem_q  <= 31'd0;
			quo_q  <= diff[31:0];
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= r_ge ? 31'(r_sh - {1'b0, dv}) : r_sh[30:0];
			quo_q  <= {quo_q[30:0], r_ge};
			dcnt_q <= dcnt_q + DIV_CW'(1);
		end
		if (cmd.clamp) begin
			idx_q <= idx_next;
		end else if (cmd.sel_idx) begin
			idx_q <= AW'(sel_q);
		end
		if (cmd.upd) begin
			cnt_q <= sample_upd ? cnt_new : rd_cnt;
			w_q   <= sample_upd ? w_new : rd_w;
		end
		if (cmd.max_cmp) begin
			if (ctr_q == '0 || $signed(rd_w) > $signed(mx_q)) begin
				mx_q <= rd_w;
			end
		end
	end

	// result preparation
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			res_status_q <= 1'b0;
			res_bin_q    <= 8'd0;
			res_cnt_q    <= 32'd0;
			res_w_q      <= 64'd0;
			res_tol_q    <= 1'b0;
		end else begin
			if (cmd.fail) res_status_q <= 1'b1;
			if (cmd.clamp) res_bin_q <= 8'(idx_next);
			if (cmd.sel_idx && func_q == FN_READ) res_bin_q <= sel_q;
			if (cmd.iter_inc) res_tol_q <= iter_next > tol_q;
			if (cmd.neg) begin
				res_cnt_q <= cnt_q;
				res_w_q   <= sat_neg(w_q);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			o_status_q <= res_status_q;
			o_bin_q    <= res_bin_q;
			o_cnt_q    <= res_cnt_q;
			o_w_q      <= res_w_q;
			o_iter_q   <= iter_q;
			o_tol_q    <= res_tol_q;
			o_total_q  <= total_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = o_status_q;
	assign bin_out       = o_bin_q;
	assign count_out     = o_cnt_q;
	assign weight_out    = o_w_q;
	assign iteration_out = o_iter_q;
	assign tol_exceeded  = o_tol_q;
	assign total_samples = o_total_q;

	// status to the controller
	always_comb begin
		stat              = '0;
		stat.func         = func_q;
		stat.in_range     = ($signed(value_q) > $signed(rmin_q)) &&
		                    ($signed(value_q) < $signed(rmax_q));
		stat.sel_ok       = 32'(sel_q) < 32'(nb);
		stat.div_last     = dcnt_q == DIV_CW'(DIV_STEPS - 1);
		stat.ctr_last_all = ctr_q == AW'(MAX_BINS - 1);
		stat.ctr_last_nb  = NBW'(ctr_q) == nb_m1;
		stat.out_free     = !out_valid_q || out_ready;
	end

endmodule

@@ hdl/histogram_bias_weight_engine.sv @@
// ----------------------------------------------------------------------------
// histogram_bias_weight_engine
// Bin count and Q16.48 bias-weight table for a biased sampler.
// ----------------------------------------------------------------------------
// After reset the block clears every entry of both tables and takes no item
// meanwhile (configuration writes are taken). Items are handled one at a
// time; the result sits in an output register so the next item may be taken
// while it waits. A sample in range passes through the bit-serial bin index
// divider, then a clamp, a table read, an update and a negation; a rejected
// sample, a set iteration, an unused code, a read and a write need no sweep.
// A reset sweeps the whole count table, one entry per cycle, and a shift
// makes two passes over the active bins, each entry a read then a compare or
// a write. The sequencer is ready for the next item in the cycle after its
// result is loaded; the load waits while an earlier result still holds the
// output register.
module histogram_bias_weight_engine #(
	parameter int MAX_BINS  = hbw_pkg::MAX_BINS_DEF,
	parameter int FRAC_BITS = hbw_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	// input items
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         func,
	input  logic signed [31:0] value,
	input  logic               in_interval,
	input  logic [7:0]         bin_sel,
	input  logic signed [63:0] weight_in,
	input  logic [5:0]         iteration_in,
	// result items
	output logic               out_valid,
	input  logic               out_ready,
	output logic               status,
	output logic [7:0]         bin_out,
	output logic [31:0]        count_out,
	output logic signed [63:0] weight_out,
	output logic [5:0]         iteration_out,
	output logic               tol_exceeded,
	output logic [31:0]        total_samples
);

	import hbw_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// sequencer
	hbw_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// datapath
	hbw_dp #(
		.MAX_BINS (MAX_BINS),
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.func         (func),
		.value        (value),
		.in_interval  (in_interval),
		.bin_sel      (bin_sel),
		.weight_in    (weight_in),
		.iteration_in (iteration_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.bin_out      (bin_out),
		.count_out    (count_out),
		.weight_out   (weight_out),
		.iteration_out(iteration_out),
		.tol_exceeded (tol_exceeded),
		.total_samples(total_samples)
	);

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the histogram and bias-weight engine. A mirror of
// the bin tables predicts one report per transfer taken in, and every report
// given out is compared field by field with the oldest prediction. A short
// directed run under the reset settings is followed by random phases, each
// with its own register settings and one of four patterns of idling and stalls.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import hbw_pkg::*;

	localparam int NBINS       = MAX_BINS_DEF;
	localparam int FRAC        = FRAC_BITS_DEF;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 50;
	localparam int TAIL_CYCLES = 4 * NBINS + 64;

	// one input item
	typedef struct {
		logic [2:0]         func;
		logic signed [31:0] value;
		logic               in_interval;
		logic [7:0]         bin_sel;
		logic signed [63:0] weight_in;
		logic [5:0]         iteration_in;
	} op_item_t;

	// one result item
	typedef struct {
		logic               status;
		logic [7:0]         bin;
		logic [31:0]        count;
		logic signed [63:0] weight;
		logic [5:0]         iteration;
		logic               tol;
		logic [31:0]        total;
	} bin_report_t;

	// mirror of the bin tables, registers and predicted reports
	class bin_table_mirror;
		logic signed [31:0] range_min;
		logic signed [31:0] range_max;
		logic [30:0]        bin_width;
		logic [8:0]         num_bins;
		logic [5:0]         iter_tol;
		logic [31:0]        counts [NBINS];
		logic signed [63:0] weights [NBINS];
		logic [5:0]         iteration;
		logic [31:0]        sample_total;
		bin_report_t        due_reports [$];
		int                 errors;

		function new();
			range_min    = RST_RANGE_MIN;
			range_max    = RST_RANGE_MAX;
			bin_width    = RST_BIN_WIDTH;
			num_bins     = RST_NUM_BINS;
			iter_tol     = RST_ITER_TOL;
			iteration    = ITER_MIN;
			sample_total = '0;
			errors       = 0;
			foreach (counts[i]) begin
				counts[i]  = '0;
				weights[i] = '0;
			end
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] data);
			case (idx)
			CFG_RANGE_MIN: range_min = data;
			CFG_RANGE_MAX: range_max = data;
			CFG_BIN_WIDTH: bin_width = data[30:0];
			CFG_NUM_BINS:  num_bins  = data[8:0];
			CFG_ITER_TOL:  iter_tol  = data[5:0];
			default: ;
			endcase
		endfunction

		function int active_bins();
			if (num_bins < 1)
				return 1;
			if (num_bins > NBINS)
				return NBINS;
			return int'(num_bins);
		endfunction

		// 65 bit sum or difference back into the signed 64 bit range
		function logic signed [63:0] clamp65(logic [64:0] wide);
			if (wide[64] != wide[63])
				return wide[64] ? W_MIN : W_MAX;
			return wide[63:0];
		endfunction

		function logic signed [63:0] neg_sat(logic signed [63:0] a);
			return (a == W_MIN) ? W_MAX : -a;
		endfunction

		// work out the report of one accepted item and update the tables
		function void predict_op(op_item_t it);
			bin_report_t        r;
			int                 nb;
			int                 h;
			longint             idx;
			logic signed [63:0] stp;
			logic signed [63:0] mx;
			nb = active_bins();
			r = '{default: 0};
			case (it.func)
			FN_SAMPLE: begin
				if (it.value > range_min && it.value < range_max) begin
					idx = (longint'(it.value) - longint'(range_min)) /
						longint'(bin_width == 0 ? 31'd1 : bin_width);
					if (idx >= nb)
						idx = nb - 1;
					if (counts[idx] != CNT_MAX)
						counts[idx]++;
					if (sample_total != CNT_MAX)
						sample_total++;
					if (it.in_interval) begin
						h = int'(iteration) - 1;
						stp = (h > FRAC) ? 64'sd0 : (64'sd1 << (FRAC - h));
						weights[idx] = clamp65({weights[idx][63], weights[idx]} +
							{stp[63], stp});
					end
					r.bin    = idx[7:0];
					r.count  = counts[idx];
					r.weight = neg_sat(weights[idx]);
				end else begin
					r.status = 1'b1;
				end
			end
			FN_RESET: begin
				if (iteration < ITER_MAX)
					iteration++;
				foreach (counts[i])
					counts[i] = '0;
				sample_total = '0;
				r.tol = (iteration > iter_tol);
			end
			FN_SHIFT: begin
				mx = weights[0];
				for (int i = 1; i < nb; i++)
					if (weights[i] > mx)
						mx = weights[i];
				for (int i = 0; i < nb; i++)
					weights[i] = clamp65({weights[i][63], weights[i]} - {mx[63], mx});
			end
			FN_READ: begin
				r.bin = it.bin_sel;
				if (it.bin_sel < nb) begin
					r.count  = counts[it.bin_sel];
					r.weight = neg_sat(weights[it.bin_sel]);
				end
			end
			FN_WRITE: begin
				if (it.bin_sel < nb)
					weights[it.bin_sel] = neg_sat(it.weight_in);
			end
			FN_SET_ITER: begin
				iteration = (it.iteration_in == 0) ? ITER_MIN : it.iteration_in;
			end
			default: ;
			endcase
			r.iteration = iteration;
			r.total     = sample_total;
			due_reports.push_back(r);
		endfunction

		function void cmp_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
			if (exp_v !== act_v) begin
				errors++;
				$display("%0t ns: %s mismatch, expected %h, actual %h",
					$time, name, exp_v, act_v);
			end
		endfunction

		// compare one report given out with the oldest prediction
		function void check_report(bin_report_t got);
			bin_report_t want;
			if (due_reports.size() == 0) begin
				errors++;
				$display("%0t ns: report with none due, expected nothing, actual bin %h count %h",
					$time, got.bin, got.count);
				return;
			end
			want = due_reports.pop_front();
			cmp_field("status", want.status, got.status);
			cmp_field("bin_out", want.bin, got.bin);
			cmp_field("count_out", want.count, got.count);
			cmp_field("weight_out", want.weight, got.weight);
			cmp_field("iteration_out", want.iteration, got.iteration);
			cmp_field("tol_exceeded", want.tol, got.tol);
			cmp_field("total_samples", want.total, got.total);
		endfunction

		function int pending();
			return due_reports.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [2:0]         func;
	logic signed [31:0] value;
	logic               in_interval;
	logic [7:0]         bin_sel;
	logic signed [63:0] weight_in;
	logic [5:0]         iteration_in;
	logic               out_valid;
	logic               out_ready;
	logic               status;
	logic [7:0]         bin_out;
	logic [31:0]        count_out;
	logic signed [63:0] weight_out;
	logic [5:0]         iteration_out;
	logic               tol_exceeded;
	logic [31:0]        total_samples;

	bin_table_mirror mirror;
	int              send_idle_pct  = 0;
	int              recv_stall_pct = 0;

	histogram_bias_weight_engine uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.value         (value),
		.in_interval   (in_interval),
		.bin_sel       (bin_sel),
		.weight_in     (weight_in),
		.iteration_in  (iteration_in),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.bin_out       (bin_out),
		.count_out     (count_out),
		.weight_out    (weight_out),
		.iteration_out (iteration_out),
		.tol_exceeded  (tol_exceeded),
		.total_samples (total_samples)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// register write transfer, valid left high for a following write
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		mirror.write_reg(idx, data);
	endtask

	// input transfer after a random idle gap, valid left high afterwards
	task automatic send_item(input op_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		func         <= it.func;
		value        <= it.value;
		in_interval  <= it.in_interval;
		bin_sel      <= it.bin_sel;
		weight_in    <= it.weight_in;
		iteration_in <= it.iteration_in;
		do
			@(posedge clk);
		while (!in_ready);
		mirror.predict_op(it);
	endtask

	task automatic send_op(input logic [2:0] f, input logic [31:0] v, input logic upd,
		input logic [7:0] sel, input logic [63:0] w, input logic [5:0] itn);
		op_item_t it;
		it.func         = f;
		it.value        = v;
		it.in_interval  = upd;
		it.bin_sel      = sel;
		it.weight_in    = w;
		it.iteration_in = itn;
		send_item(it);
	endtask

	task automatic wait_drained();
		while (mirror.pending() != 0)
			@(posedge clk);
	endtask

	// register settings and idling pattern of one random phase
	task automatic setup_phase(input int p);
		logic [31:0] lo;
		lo = $urandom;
		case (p)
		0: begin
			write_reg(CFG_RANGE_MIN, -32'sd100);
			write_reg(CFG_RANGE_MAX, 32'd1000);
			write_reg(CFG_BIN_WIDTH, 32'd7);
			write_reg(CFG_NUM_BINS, 32'd64);
			write_reg(CFG_ITER_TOL, 32'd10);
		end
		1: begin
			write_reg(CFG_RANGE_MIN, 32'h8000_0000);
			write_reg(CFG_RANGE_MAX, 32'h7FFF_FFFF);
			write_reg(CFG_BIN_WIDTH, 32'h7FFF_FFFF);
			write_reg(CFG_NUM_BINS, 32'd511);
			write_reg(CFG_ITER_TOL, 32'd63);
		end
		2: begin
			// zero width and zero bins
			write_reg(CFG_RANGE_MIN, 32'd0);
			write_reg(CFG_RANGE_MAX, 32'd50);
			write_reg(CFG_BIN_WIDTH, 32'd0);
			write_reg(CFG_NUM_BINS, 32'd0);
			write_reg(CFG_ITER_TOL, 32'd0);
		end
		3: begin
			// empty range, bin count over the table size
			write_reg(CFG_RANGE_MIN, 32'd10);
			write_reg(CFG_RANGE_MAX, -32'sd10);
			write_reg(CFG_BIN_WIDTH, 32'd3);
			write_reg(CFG_NUM_BINS, 32'd300);
			write_reg(CFG_ITER_TOL, 32'd40);
		end
		4: begin
			// range wider than the bins, samples pile up in the last bin
			write_reg(CFG_RANGE_MIN, -32'sd1000);
			write_reg(CFG_RANGE_MAX, 32'd5000);
			write_reg(CFG_BIN_WIDTH, 32'd1);
			write_reg(CFG_NUM_BINS, 32'd256);
			write_reg(CFG_ITER_TOL, 32'd25);
		end
		5: begin
			// unused high bits set on the bin width, random on bin count and tolerance
			write_reg(CFG_RANGE_MIN, lo);
			write_reg(CFG_RANGE_MAX, lo + $urandom_range(1, 5000));
			write_reg(CFG_BIN_WIDTH, 32'h8000_0000 | $urandom_range(1, 40));
			write_reg(CFG_NUM_BINS, $urandom);
			write_reg(CFG_ITER_TOL, $urandom);
		end
		6: begin
			write_reg(CFG_RANGE_MIN, -32'sd5);
			write_reg(CFG_RANGE_MAX, 32'd20);
			write_reg(CFG_BIN_WIDTH, 32'd2);
			write_reg(CFG_NUM_BINS, 32'd8);
			write_reg(CFG_ITER_TOL, 32'd5);
		end
		default: begin
			write_reg(CFG_RANGE_MIN, -32'sd300);
			write_reg(CFG_RANGE_MAX, 32'd300);
			write_reg(CFG_BIN_WIDTH, 32'd5);
			write_reg(CFG_NUM_BINS, 32'd128);
			write_reg(CFG_ITER_TOL, 32'd30);
		end
		endcase
		cfg_valid <= 1'b0;
		case (p % 4)
		0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
		1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
		2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
		default: begin send_idle_pct = 16; recv_stall_pct = 16; end
		endcase
	endtask

	// random item shaped by the current settings
	function automatic op_item_t random_item();
		op_item_t    it;
		int          r;
		int          nb;
		int          shift_pct;
		longint      lo;
		longint      hi;
		longint      v;
		int unsigned w;
		nb = mirror.active_bins();
		w = (mirror.bin_width == 0) ? 1 : mirror.bin_width;
		lo = longint'(mirror.range_min) + 1;
		hi = longint'(mirror.range_max) - 1;
		shift_pct = (nb > 64) ? 2 : 6;
		it.func         = FN_SAMPLE;
		it.value        = $urandom;
		it.in_interval  = $urandom_range(1);
		it.bin_sel      = $urandom;
		it.weight_in    = {$urandom, $urandom};
		it.iteration_in = $urandom;
		r = $urandom_range(99);
		if (r < 56) begin
			case ($urandom_range(9))
			0, 1, 2, 3, 4, 5, 6: begin
				// value in range, spread over the bins and just past them
				if (hi >= lo) begin
					v = lo + longint'($urandom_range(nb + 1)) * longint'(w) +
						longint'($urandom_range(w - 1));
					if (v > hi)
						v = hi - longint'($urandom_range(w - 1));
					if (v < lo)
						v = lo;
					it.value = v[31:0];
				end
			end
			7: begin
				case ($urandom_range(3))
				0: it.value = mirror.range_min;
				1: it.value = mirror.range_max;
				2: it.value = lo[31:0];
				default: it.value = hi[31:0];
				endcase
			end
			default: ;
			endcase
		end else if (r < 68) begin
			it.func = FN_READ;
			if ($urandom_range(3) != 0)
				it.bin_sel = $urandom_range(nb + 1);
		end else if (r < 78) begin
			it.func = FN_WRITE;
			if ($urandom_range(3) != 0)
				it.bin_sel = $urandom_range(nb + 1);
			case ($urandom_range(3))
			0: ;
			1: begin
				it.weight_in = longint'($urandom_range(65536)) << $urandom_range(40);
				if ($urandom_range(1))
					it.weight_in = -it.weight_in;
			end
			2: begin
				case ($urandom_range(3))
				0: it.weight_in = W_MIN;
				1: it.weight_in = W_MAX;
				2: it.weight_in = W_MIN + 1;
				default: it.weight_in = W_MAX - 1;
				endcase
			end
			default: begin
				// stored weight a few steps below the positive limit
				it.weight_in = W_MIN + (longint'($urandom_range(3)) << FRAC);
			end
			endcase
		end else if (r < 84) begin
			it.func = FN_SET_ITER;
			if ($urandom_range(4) != 0)
				it.iteration_in = $urandom_range(12);
		end else if (r < 89) begin
			it.func = FN_RESET;
		end else if (r < 89 + shift_pct) begin
			it.func = FN_SHIFT;
		end else if (r >= 95) begin
			it.func = ($urandom_range(1) != 0) ? 3'd7 : 3'd6;
		end
		return it;
	endfunction

	// receiver: check each report transfer, then choose the next ready
	initial begin
		bin_report_t got;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready) begin
				got.status    = status;
				got.bin       = bin_out;
				got.count     = count_out;
				got.weight    = weight_out;
				got.iteration = iteration_out;
				got.tol       = tol_exceeded;
				got.total     = total_samples;
				mirror.check_report(got);
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// main sequence
	initial begin
		op_item_t it;
		int       n;
		mirror = new();
		arst_n       <= 1'b0;
		cfg_valid    <= 1'b0;
		cfg_index    <= '0;
		cfg_data     <= '0;
		in_valid     <= 1'b0;
		func         <= '0;
		value        <= '0;
		in_interval  <= 1'b0;
		bin_sel      <= '0;
		weight_in    <= '0;
		iteration_in <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under the reset settings
		send_op(FN_READ, 32'd0, 1'b0, 8'd0, 64'd0, 6'd0);
		send_op(FN_SAMPLE, 32'd5, 1'b1, 8'd0, 64'd0, 6'd0);
		send_op(FN_SAMPLE, 32'd5, 1'b0, 8'd0, 64'd0, 6'd0);
		// exclusive bounds and extreme values are rejected, the value below the top bound is taken
		send_op(FN_SAMPLE, 32'd0, 1'b1, 8'd0, 64'd0, 6'd0);
		send_op(FN_SAMPLE, 32'd256, 1'b1, 8'd0, 64'd0, 6'd0);
		send_op(FN_SAMPLE, 32'd255, 1'b1, 8'd0, 64'd0, 6'd0);
		send_op(FN_SAMPLE, 32'h8000_0000, 1'b1, 8'd0, 64'd0, 6'd0);
		send_op(FN_SAMPLE, 32'h7FFF_FFFF, 1'b1, 8'd0, 64'd0, 6'd0);
		// weight saturation at both ends, shift into the negative limit
		send_op(FN_WRITE, 32'd0, 1'b0, 8'd3, W_MIN, 6'd0);
		send_op(FN_SAMPLE, 32'd3, 1'b1, 8'd0, 64'd0, 6'd0);
		send_op(FN_WRITE, 32'd0, 1'b0, 8'd4, W_MAX, 6'd0);
		send_op(FN_SHIFT, 32'd0, 1'b0, 8'd0, 64'd0, 6'd0);
		send_op(FN_READ, 32'd0, 1'b0, 8'd4, 64'd0, 6'd0);
		send_op(FN_WRITE, 32'd0, 1'b0, 8'd255, -64'sd1, 6'd0);
		send_op(FN_READ, 32'd0, 1'b0, 8'd255, 64'd0, 6'd0);
		// iteration zero, step vanishing, smallest step
		send_op(FN_SET_ITER, 32'd0, 1'b0, 8'd0, 64'd0, 6'd0);
		send_op(FN_SET_ITER, 32'd0, 1'b0, 8'd0, 64'd0, 6'd50);
		send_op(FN_SAMPLE, 32'd10, 1'b1, 8'd0, 64'd0, 6'd0);
		send_op(FN_SET_ITER, 32'd0, 1'b0, 8'd0, 64'd0, 6'd49);
		send_op(FN_SAMPLE, 32'd10, 1'b1, 8'd0, 64'd0, 6'd0);
		// iteration ceiling and tolerance edge
		send_op(FN_SET_ITER, 32'd0, 1'b0, 8'd0, 64'd0, 6'd63);
		send_op(FN_RESET, 32'd0, 1'b0, 8'd0, 64'd0, 6'd0);
		send_op(FN_SET_ITER, 32'd0, 1'b0, 8'd0, 64'd0, 6'd24);
		send_op(FN_RESET, 32'd0, 1'b0, 8'd0, 64'd0, 6'd0);
		send_op(FN_RESET, 32'd0, 1'b0, 8'd0, 64'd0, 6'd0);
		// unused codes
		send_op(3'd6, 32'd7, 1'b1, 8'd7, 64'd7, 6'd7);
		send_op(3'd7, 32'd9, 1'b1, 8'd9, 64'd9, 6'd9);
		in_valid <= 1'b0;

		// random phases
		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			setup_phase(p);
			n = 0;
			while (n < PHASE_ITEMS) begin
				it = random_item();
				send_item(it);
				if (it.func <= FN_SET_ITER)
					n++;
			end
			in_valid <= 1'b0;
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mirror.errors == 0 && mirror.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// run limit
	initial begin
		#(4_000_000);
		$display("TB_ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/hbw_pkg.sv
hdl/hbw_ram.sv
hdl/hbw_ctrl.sv
hdl/hbw_dp.sv
hdl/histogram_bias_weight_engine.sv
tb/testbench.sv
